FILE: design/lcdns_pkg.sv
// lcdns_pkg: shared types, codes and constants for the character lcd nibble sequencer
// no dependencies; imported by every module of the block

package lcdns_pkg;

    // opcodes of a request
    localparam logic [2:0] OP_INIT       = 3'd0;
    localparam logic [2:0] OP_COMMAND    = 3'd1;
    localparam logic [2:0] OP_CHAR       = 3'd2;
    localparam logic [2:0] OP_SET_POS    = 3'd3;
    localparam logic [2:0] OP_CHAR_AT    = 3'd4;
    localparam logic [2:0] OP_GLYPH      = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_POWER_UP_WAIT = 2'd0;
    localparam logic [1:0] CFG_CLEAR_WAIT    = 2'd1;
    localparam logic [1:0] CFG_COMMAND_WAIT  = 2'd2;
    localparam logic [1:0] CFG_DATA_WAIT     = 2'd3;

    // reset values of the configuration registers
    localparam logic [15:0] POWER_UP_WAIT_RST = 16'd20000;
    localparam logic [15:0] CLEAR_WAIT_RST    = 16'd2000;
    localparam logic [9:0]  COMMAND_WAIT_RST  = 10'd37;
    localparam logic [9:0]  DATA_WAIT_RST     = 10'd41;

    // display commands and addresses
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] ADDR_ROW1        = 8'h80;
    localparam logic [7:0] ADDR_ROW2        = 8'hC0;
    localparam logic [7:0] ADDR_CGRAM       = 8'h40;

    // init wake-up nibbles and their fixed waits
    localparam logic [3:0]  INIT_NIB_WAKE = 4'h3;
    localparam logic [3:0]  INIT_NIB_4BIT = 4'h2;
    localparam logic [15:0] WAIT_NIB1     = 16'd5000;
    localparam logic [15:0] WAIT_NIB2     = 16'd100;
    localparam logic [15:0] WAIT_NIB3     = 16'd1000;
    localparam logic [15:0] WAIT_NIB4     = 16'd1000;

    // step numbers inside the init sequence
    localparam logic [4:0] INIT_STEP_POWER = 5'd0;
    localparam logic [4:0] INIT_STEP_NIB1  = 5'd1;
    localparam logic [4:0] INIT_STEP_NIB2  = 5'd2;
    localparam logic [4:0] INIT_STEP_NIB3  = 5'd3;
    localparam logic [4:0] INIT_STEP_NIB4  = 5'd4;
    localparam logic [4:0] INIT_STEP_CMD   = 5'd5;

    // index of the final strobe for each kind of request
    localparam logic [4:0] LAST_INIT     = 5'd12;
    localparam logic [4:0] LAST_ONE_BYTE = 5'd1;
    localparam logic [4:0] LAST_TWO_BYTE = 5'd3;
    localparam logic [4:0] LAST_GLYPH    = 5'd17;

    // classified request handed from front to back
    typedef struct packed {
        logic        is_init;
        logic        has_cmd;
        logic [4:0]  last_step;
        logic [7:0]  cmd;
        logic [63:0] data;
    } req_t;

    // configured waits
    typedef struct packed {
        logic [15:0] power_up_wait;
        logic [15:0] clear_wait;
        logic [9:0]  command_wait;
        logic [9:0]  data_wait;
    } cfg_t;

    // one bus step
    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic        strobe_res;
        logic [15:0] wait_us;
        logic        last;
    } step_t;

    // command bytes sent after the wake-up nibbles
    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = CMD_FUNCTION_SET;
            2'd1: c = CMD_DISPLAY_ON;
            2'd2: c = CMD_CLEAR;
            2'd3: c = CMD_ENTRY_MODE;
            default: c = CMD_FUNCTION_SET;
        endcase
        return c;
    endfunction

    // wait after a command byte: clear and home are slow
    function automatic logic [15:0] cmd_wait(input logic [7:0] c, input cfg_t cfg);
        logic [15:0] w;
        if (c == CMD_CLEAR || c == CMD_HOME)
            w = cfg.clear_wait;
        else
            w = {6'd0, cfg.command_wait};
        return w;
    endfunction

endpackage

FILE: design/lcdns_front.sv
// lcdns_front: decodes a request into a compact descriptor for the back end
// depends on lcdns_pkg

module lcdns_front
    import lcdns_pkg::*;
(
    input  logic [2:0]  opcode,
    input  logic [7:0]  value,
    input  logic [1:0]  row,
    input  logic [5:0]  column,
    input  logic [2:0]  glyph_slot,
    input  logic [63:0] glyph_rows,
    output logic        req_valid,
    output req_t        req
);

    logic [7:0] pos_base;
    logic [7:0] pos_addr;
    logic [7:0] cgram_addr;

    assign pos_base   = (row == 2'd1) ? ADDR_ROW1 : ADDR_ROW2;
    assign pos_addr   = pos_base + {2'd0, column} - 8'd1;
    assign cgram_addr = ADDR_CGRAM + {2'd0, glyph_slot, 3'd0};

    always_comb
    begin
        req_valid     = 1'b1;
        req.is_init   = 1'b0;
        req.has_cmd   = 1'b0;
        req.last_step = LAST_ONE_BYTE;
        req.cmd       = value;
        req.data      = {56'd0, value};
        unique case (opcode)
            OP_INIT:
            begin
                req.is_init   = 1'b1;
                req.last_step = LAST_INIT;
            end
            OP_COMMAND:
            begin
                req.has_cmd = 1'b1;
            end
            OP_CHAR:
            begin
                req.has_cmd = 1'b0;
            end
            OP_SET_POS:
            begin
                req.has_cmd = 1'b1;
                req.cmd     = pos_addr;
            end
            OP_CHAR_AT:
            begin
                req.has_cmd   = 1'b1;
                req.cmd       = pos_addr;
                req.last_step = LAST_TWO_BYTE;
            end
            OP_GLYPH:
            begin
                req.has_cmd   = 1'b1;
                req.cmd       = cgram_addr;
                req.data      = glyph_rows;
                req.last_step = LAST_GLYPH;
            end
            default:
            begin
                // unused opcodes make no strobes
                req_valid = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/lcdns_queue.sv
// lcdns_queue: two-entry descriptor queue between front and back
// depends on lcdns_pkg

module lcdns_queue
    import lcdns_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_req,
    input  logic pop,
    output req_t pop_req,
    output logic full,
    output logic empty
);

    req_t       mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_req = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/lcdns_back.sv
// lcdns_back: steps through one descriptor, one bus strobe per cycle
// depends on lcdns_pkg

module lcdns_back
    import lcdns_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_empty,
    input  req_t  q_req,
    output logic  q_pop,
    output logic  out_valid,
    output step_t out_step
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic        is_init_reg;
    logic        cmd_pending_reg;
    logic        cmd_pending_next;
    logic [7:0]  cmd_reg;
    logic [63:0] data_reg;
    logic [63:0] data_next;
    logic [4:0]  step_reg;
    logic [4:0]  step_next;
    logic [4:0]  last_step_reg;
    logic        valid_reg;
    step_t       step_out_reg;

    step_t       cur;
    logic        at_last;
    logic        load;
    logic [4:0]  init_ofs;
    logic [7:0]  byte_cur;
    logic        phase;

    assign init_ofs = step_reg - INIT_STEP_CMD;
    assign at_last  = (step_reg == last_step_reg);

    // current strobe from the working state
    always_comb
    begin
        cur      = '0;
        byte_cur = 8'd0;
        phase    = 1'b0;
        cur.last = at_last;
        if (is_init_reg)
        begin
            unique case (step_reg)
                INIT_STEP_POWER:
                begin
                    cur.wait_us = cfg.power_up_wait;
                end
                INIT_STEP_NIB1:
                begin
                    cur.nibble     = INIT_NIB_WAKE;
                    cur.strobe_res = 1'b1;
                    cur.wait_us    = WAIT_NIB1;
                end
                INIT_STEP_NIB2:
                begin
                    cur.nibble     = INIT_NIB_WAKE;
                    cur.strobe_res = 1'b1;
                    cur.wait_us    = WAIT_NIB2;
                end
                INIT_STEP_NIB3:
                begin
                    cur.nibble     = INIT_NIB_WAKE;
                    cur.strobe_res = 1'b1;
                    cur.wait_us    = WAIT_NIB3;
                end
                INIT_STEP_NIB4:
                begin
                    cur.nibble     = INIT_NIB_4BIT;
                    cur.strobe_res = 1'b1;
                    cur.wait_us    = WAIT_NIB4;
                end
                default:
                begin
                    byte_cur       = init_cmd(init_ofs[2:1]);
                    phase          = init_ofs[0];
                    cur.strobe_res = 1'b1;
                    cur.nibble     = phase ? byte_cur[3:0] : byte_cur[7:4];
                    cur.wait_us    = phase ? cmd_wait(byte_cur, cfg) : 16'd0;
                end
            endcase
        end
        else
        begin
            byte_cur       = cmd_pending_reg ? cmd_reg : data_reg[7:0];
            phase          = step_reg[0];
            cur.reg_select = ~cmd_pending_reg;
            cur.strobe_res = 1'b1;
            cur.nibble     = phase ? byte_cur[3:0] : byte_cur[7:4];
            if (!phase)
                cur.wait_us = 16'd0;
            else if (cmd_pending_reg)
                cur.wait_us = cmd_wait(byte_cur, cfg);
            else
                cur.wait_us = {6'd0, cfg.data_wait};
        end
    end

    // take the next descriptor when idle or on the final strobe
    assign load  = !q_empty && ((state_reg == ST_IDLE) || at_last);
    assign q_pop = load;

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        cmd_pending_next = cmd_pending_reg;
        data_next        = data_reg;
        if (state_reg == ST_RUN)
        begin
            step_next = step_reg + 5'd1;
            if (!is_init_reg && step_reg[0])
            begin
                if (cmd_pending_reg)
                    cmd_pending_next = 1'b0;
                else
                    data_next = {8'd0, data_reg[63:8]};
            end
            if (at_last)
                state_next = ST_IDLE;
        end
        if (load)
        begin
            state_next       = ST_RUN;
            step_next        = 5'd0;
            cmd_pending_next = q_req.has_cmd;
            data_next        = q_req.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == ST_RUN);
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        cmd_pending_reg <= cmd_pending_next;
        data_reg        <= data_next;
        step_out_reg    <= cur;
        if (load)
        begin
            is_init_reg   <= q_req.is_init;
            cmd_reg       <= q_req.cmd;
            last_step_reg <= q_req.last_step;
        end
    end

    assign out_valid = valid_reg;
    assign out_step  = step_out_reg;

endmodule

FILE: design/char_lcd_nibble_sequencer.sv
// char_lcd_nibble_sequencer: top level of the 4-bit character lcd strobe sequencer
// depends on lcdns_pkg, lcdns_front, lcdns_queue, lcdns_back

// Each request becomes a run of bus strobes, one strobe per clock cycle: a
// command, a set-position or a plain character makes 2 strobes, a character at
// a position 4, init 13 and define glyph 18; opcodes 6 and 7 are taken and
// make nothing. The back-end sequencer, which emits one strobe per cycle, sets
// that rate. Requests enter through a two-entry queue, so start is taken
// while an earlier request is still being sent out, and busy rises only when
// the queue is full. If the sequencer is free, a taken request passes the
// queue, the back end's working registers and its output register before its
// first strobe; queued requests follow with no gap. Each strobe is shown for
// exactly one cycle with strobe high; the receiver cannot stall it, so it must
// take every strobe as it comes. The waits in wait_us are for the receiver to
// carry out; this block does not count them. Configuration writes land at once
// and should only be made while nothing is queued or being sent.

module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [7:0]  value,
    input  logic [1:0]  row,
    input  logic [5:0]  column,
    input  logic [2:0]  glyph_slot,
    input  logic [63:0] glyph_rows,

    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // strobe channel
    output logic        strobe,
    output logic        reg_select,
    output logic [3:0]  nibble,
    output logic        strobe_res,
    output logic [15:0] wait_us,
    output logic        last
);

    cfg_t  cfg_reg;
    req_t  front_req;
    logic  front_valid;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    req_t  q_req;
    logic  out_valid;
    step_t out_step;

    // configuration registers, written straight from the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_up_wait <= POWER_UP_WAIT_RST;
            cfg_reg.clear_wait    <= CLEAR_WAIT_RST;
            cfg_reg.command_wait  <= COMMAND_WAIT_RST;
            cfg_reg.data_wait     <= DATA_WAIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POWER_UP_WAIT: cfg_reg.power_up_wait <= cfg_data;
                CFG_CLEAR_WAIT:    cfg_reg.clear_wait    <= cfg_data;
                CFG_COMMAND_WAIT:  cfg_reg.command_wait  <= cfg_data[9:0];
                CFG_DATA_WAIT:     cfg_reg.data_wait     <= cfg_data[9:0];
                default:           cfg_reg.data_wait     <= cfg_reg.data_wait;
            endcase
        end
    end

    // front: decode the request
    lcdns_front u_front (
        .opcode     (opcode),
        .value      (value),
        .row        (row),
        .column     (column),
        .glyph_slot (glyph_slot),
        .glyph_rows (glyph_rows),
        .req_valid  (front_valid),
        .req        (front_req)
    );

    // a word is taken when start is high and the queue has room
    assign busy   = q_full;
    assign q_push = start && !q_full && front_valid;

    lcdns_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_req (front_req),
        .pop      (q_pop),
        .pop_req  (q_req),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back: one strobe per cycle
    lcdns_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_req     (q_req),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_step  (out_step)
    );

    assign strobe     = out_valid;
    assign reg_select = out_step.reg_select;
    assign nibble     = out_step.nibble;
    assign strobe_res = out_step.strobe_res;
    assign wait_us    = out_step.wait_us;
    assign last       = out_step.last;

endmodule

FILE: dv/char_lcd_nibble_sequencer_checker.sv
// char_lcd_nibble_sequencer_checker: predicts the strobe words of the lcd nibble sequencer
// and compares them with what the block sends; depends on lcdns_pkg

module char_lcd_nibble_sequencer_checker
    import lcdns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  opcode,
    input  logic [7:0]  value,
    input  logic [1:0]  row,
    input  logic [5:0]  column,
    input  logic [2:0]  glyph_slot,
    input  logic [63:0] glyph_rows,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        strobe,
    input  logic        reg_select,
    input  logic [3:0]  nibble,
    input  logic        strobe_res,
    input  logic [15:0] wait_us,
    input  logic        last,
    output int          failures,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the wait registers
    logic [15:0] power_up_wait_sh;
    logic [15:0] clear_wait_sh;
    logic [9:0]  command_wait_sh;
    logic [9:0]  data_wait_sh;

    step_t lcd_steps_q[$];
    step_t req_steps[0:17];
    int    req_len;
    int    fail_count = 0;

    assign failures = fail_count;

    task automatic add_step(input logic rs, input logic [3:0] nib, input logic pulse,
                            input logic [15:0] w);
        req_steps[req_len] = {rs, nib, pulse, w, 1'b0};
        req_len++;
    endtask

    // high nibble carries no wait, low nibble carries the wait of the byte
    task automatic add_byte(input logic rs, input logic [7:0] b, input logic [15:0] w);
        add_step(rs, b[7:4], 1'b1, 16'd0);
        add_step(rs, b[3:0], 1'b1, w);
    endtask

    task automatic add_command(input logic [7:0] c);
        if (c == CMD_CLEAR || c == CMD_HOME)
            add_byte(1'b0, c, clear_wait_sh);
        else
            add_byte(1'b0, c, {6'd0, command_wait_sh});
    endtask

    task automatic add_char(input logic [7:0] ch);
        add_byte(1'b1, ch, {6'd0, data_wait_sh});
    endtask

    function automatic logic [7:0] position_address(input logic [1:0] r, input logic [5:0] col);
        logic [7:0] base;
        base = (r == 2'd1) ? ADDR_ROW1 : ADDR_ROW2;
        return base + {2'b00, col} - 8'd1;
    endfunction

    task automatic expand_request(input logic [2:0] op, input logic [7:0] val,
                                  input logic [1:0] r, input logic [5:0] col,
                                  input logic [2:0] slot, input logic [63:0] rows);
        step_t s;
        req_len = 0;
        case (op)
            OP_INIT:
            begin
                add_step(1'b0, 4'h0, 1'b0, power_up_wait_sh);
                add_step(1'b0, INIT_NIB_WAKE, 1'b1, WAIT_NIB1);
                add_step(1'b0, INIT_NIB_WAKE, 1'b1, WAIT_NIB2);
                add_step(1'b0, INIT_NIB_WAKE, 1'b1, WAIT_NIB3);
                add_step(1'b0, INIT_NIB_4BIT, 1'b1, WAIT_NIB4);
                add_command(CMD_FUNCTION_SET);
                add_command(CMD_DISPLAY_ON);
                add_command(CMD_CLEAR);
                add_command(CMD_ENTRY_MODE);
            end
            OP_COMMAND: add_command(val);
            OP_CHAR:    add_char(val);
            OP_SET_POS: add_command(position_address(r, col));
            OP_CHAR_AT:
            begin
                add_command(position_address(r, col));
                add_char(val);
            end
            OP_GLYPH:
            begin
                add_command(ADDR_CGRAM + {2'b00, slot, 3'b000});
                for (int i = 0; i < 8; i++)
                    add_char(rows[8*i +: 8]);
            end
            default: ;
        endcase
        for (int i = 0; i < req_len; i++)
        begin
            s = req_steps[i];
            if (i == req_len - 1)
                s.last = 1'b1;
            lcd_steps_q.push_back(s);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        step_t want;
        if (!rst_n)
        begin
            power_up_wait_sh <= POWER_UP_WAIT_RST;
            clear_wait_sh    <= CLEAR_WAIT_RST;
            command_wait_sh  <= COMMAND_WAIT_RST;
            data_wait_sh     <= DATA_WAIT_RST;
            lcd_steps_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POWER_UP_WAIT: power_up_wait_sh <= cfg_data;
                    CFG_CLEAR_WAIT:    clear_wait_sh    <= cfg_data;
                    CFG_COMMAND_WAIT:  command_wait_sh  <= cfg_data[9:0];
                    CFG_DATA_WAIT:     data_wait_sh     <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (strobe)
            begin
                if (lcd_steps_q.size() == 0)
                begin
                    $error("strobe word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = lcd_steps_q.pop_front();
                    check_field("reg_select", 16'(want.reg_select), 16'(reg_select));
                    check_field("nibble", 16'(want.nibble), 16'(nibble));
                    check_field("strobe_res", 16'(want.strobe_res), 16'(strobe_res));
                    check_field("wait_us", want.wait_us, wait_us);
                    check_field("last", 16'(want.last), 16'(last));
                end
            end
            if (start && !busy)
                expand_request(opcode, value, row, column, glyph_slot, glyph_rows);
            pending <= lcd_steps_q.size();
        end
    end

endmodule

FILE: dv/char_lcd_nibble_sequencer_tb.sv
// char_lcd_nibble_sequencer_tb: stimulus and verdict for the lcd nibble sequencer
// depends on lcdns_pkg, char_lcd_nibble_sequencer and char_lcd_nibble_sequencer_checker

module char_lcd_nibble_sequencer_tb
    import lcdns_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // opcodes the block takes but turns into nothing
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    // cycles to let pass after the last expected word, so a stray word would be caught
    localparam int DRAIN_CYCLES = 40;
    // bound on the wait for outstanding words
    localparam int SETTLE_LIMIT = 4000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    logic [2:0]  opcode     = OP_INIT;
    logic [7:0]  value      = 8'd0;
    logic [1:0]  row        = 2'd0;
    logic [5:0]  column     = 6'd0;
    logic [2:0]  glyph_slot = 3'd0;
    logic [63:0] glyph_rows = 64'd0;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_index  = CFG_POWER_UP_WAIT;
    logic [15:0] cfg_data   = 16'd0;
    logic        strobe;
    logic        reg_select;
    logic [3:0]  nibble;
    logic        strobe_res;
    logic [15:0] wait_us;
    logic        last;

    int failures;
    int pending;
    int stall_errors = 0;

    char_lcd_nibble_sequencer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .value      (value),
        .row        (row),
        .column     (column),
        .glyph_slot (glyph_slot),
        .glyph_rows (glyph_rows),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .strobe     (strobe),
        .reg_select (reg_select),
        .nibble     (nibble),
        .strobe_res (strobe_res),
        .wait_us    (wait_us),
        .last       (last)
    );

    // watches both channels and the config port, predicts and compares
    char_lcd_nibble_sequencer_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .value      (value),
        .row        (row),
        .column     (column),
        .glyph_slot (glyph_slot),
        .glyph_rows (glyph_rows),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .strobe     (strobe),
        .reg_select (reg_select),
        .nibble     (nibble),
        .strobe_res (strobe_res),
        .wait_us    (wait_us),
        .last       (last),
        .failures   (failures),
        .pending    (pending)
    );

    // 8 ns clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // present one request word and hold it until the block takes it;
    // busy read right after the edge is its value before the edge, so
    // leaving the loop means the word was taken at this edge.
    // start is left high so the next word can follow without a gap
    task automatic send_word(input logic [2:0] op, input logic [7:0] val,
                             input logic [1:0] r, input logic [5:0] col,
                             input logic [2:0] slot, input logic [63:0] rows);
        start      <= 1'b1;
        opcode     <= op;
        value      <= val;
        row        <= r;
        column     <= col;
        glyph_slot <= slot;
        glyph_rows <= rows;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // random idle burst on the request side, about one word in four
    task automatic idle_burst(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // one random request word; mostly well-formed opcodes, a few spare ones,
    // columns mostly on the display with some wrapping ones (0 and past 40)
    task automatic send_random(input bit allow_idle);
        int          pick;
        logic [2:0]  op;
        logic [7:0]  val;
        logic [5:0]  col;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            op = OP_INIT;
        else if (pick < 26)
            op = OP_COMMAND;
        else if (pick < 44)
            op = OP_CHAR;
        else if (pick < 60)
            op = OP_SET_POS;
        else if (pick < 78)
            op = OP_CHAR_AT;
        else if (pick < 94)
            op = OP_GLYPH;
        else if (pick < 97)
            op = OP_SPARE_A;
        else
            op = OP_SPARE_B;
        val = 8'($urandom);
        // steer some commands onto clear and home so the slow wait shows up
        if (op == OP_COMMAND && $urandom_range(0, 3) == 0)
            val = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
        if ($urandom_range(0, 4) == 0)
            col = 6'($urandom_range(0, 63));
        else
            col = 6'($urandom_range(1, 40));
        send_word(op, val, 2'($urandom_range(0, 3)), col, 3'($urandom_range(0, 7)),
                  {$urandom, $urandom});
        idle_burst(allow_idle);
    endtask

    // drop start and wait until every expected word has come, then let
    // DRAIN_CYCLES more pass so that a stray word would still be caught
    task automatic settle();
        int waited;
        waited = 0;
        start <= 1'b0;
        // pending is a registered copy of the checker's queue size
        repeat (2) @(posedge clk);
        while (pending != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending != 0)
        begin
            $error("%0d strobe words still expected after %0d cycles", pending, waited);
            stall_errors++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all four wait registers on consecutive edges; only called when idle
    task automatic write_waits(input logic [15:0] power_up, input logic [15:0] clear_w,
                               input logic [15:0] command_w, input logic [15:0] data_w);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POWER_UP_WAIT;
        cfg_data  <= power_up;
        @(posedge clk);
        cfg_index <= CFG_CLEAR_WAIT;
        cfg_data  <= clear_w;
        @(posedge clk);
        cfg_index <= CFG_COMMAND_WAIT;
        cfg_data  <= command_w;
        @(posedge clk);
        cfg_index <= CFG_DATA_WAIT;
        cfg_data  <= data_w;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed words at the reset waits, sent back to back so the queue fills
        send_word(OP_INIT, 8'h00, 2'd0, 6'd1, 3'd0, 64'd0);
        send_word(OP_COMMAND, CMD_CLEAR, 2'd0, 6'd1, 3'd0, 64'd0);
        send_word(OP_COMMAND, CMD_HOME, 2'd0, 6'd1, 3'd0, 64'd0);
        send_word(OP_COMMAND, 8'h00, 2'd0, 6'd1, 3'd0, 64'd0);
        send_word(OP_COMMAND, 8'hFF, 2'd0, 6'd1, 3'd0, 64'd0);
        send_word(OP_COMMAND, CMD_ENTRY_MODE, 2'd0, 6'd1, 3'd0, 64'd0);
        send_word(OP_CHAR, 8'h00, 2'd0, 6'd1, 3'd0, 64'd0);
        send_word(OP_CHAR, 8'hFF, 2'd3, 6'd63, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_CHAR, 8'h41, 2'd1, 6'd1, 3'd0, 64'd0);
        // first row, second row, and addresses that wrap
        send_word(OP_SET_POS, 8'h00, 2'd1, 6'd1, 3'd0, 64'd0);
        send_word(OP_SET_POS, 8'h00, 2'd0, 6'd40, 3'd0, 64'd0);
        send_word(OP_SET_POS, 8'h00, 2'd2, 6'd0, 3'd0, 64'd0);
        send_word(OP_SET_POS, 8'h00, 2'd3, 6'd63, 3'd0, 64'd0);
        send_word(OP_SET_POS, 8'h00, 2'd1, 6'd63, 3'd0, 64'd0);
        send_word(OP_SET_POS, 8'h00, 2'd1, 6'd0, 3'd0, 64'd0);
        send_word(OP_CHAR_AT, 8'hA5, 2'd1, 6'd40, 3'd0, 64'd0);
        send_word(OP_CHAR_AT, 8'h5A, 2'd2, 6'd1, 3'd0, 64'd0);
        // glyph at the first and last location
        send_word(OP_GLYPH, 8'h00, 2'd0, 6'd1, 3'd0, 64'd0);
        send_word(OP_GLYPH, 8'h00, 2'd0, 6'd1, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_GLYPH, 8'h00, 2'd0, 6'd1, 3'd3, 64'h0123_4567_89AB_CDEF);
        // spare opcodes make nothing, then a normal word must still come out right
        send_word(OP_SPARE_A, 8'hFF, 2'd3, 6'd63, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_SPARE_B, 8'h00, 2'd0, 6'd0, 3'd0, 64'd0);
        send_word(OP_INIT, 8'h00, 2'd0, 6'd1, 3'd0, 64'd0);
        settle();

        // random phases, each with its own wait settings; the last has no idling
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_waits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: write_waits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                2: write_waits(16'hFFFF, 16'h0001, 16'h03FF, 16'h0000);
                default: write_waits(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom));
            endcase
            repeat (90) send_random(phase != 4);
            settle();
        end

        if (failures == 0 && stall_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
